// File: rtl/pcbp_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the prefix code bit packer.
// No dependencies; every other file imports this package.
package pcbp_pkg;

  localparam int SYM_W  = 8;
  localparam int CODE_W = 32;
  localparam int LEN_W  = 6;
  localparam int BYTE_W = 8;
  localparam int VB_W   = 4;

  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_START  = 2'd1,
    OP_ENCODE = 2'd2,
    OP_FINISH = 2'd3
  } opcode_t;

  // Command classes handed from the front end to the byte sequencer.
  typedef enum logic [2:0] {
    K_ACK      = 3'd0,
    K_START    = 3'd1,
    K_ENCODE   = 3'd2,
    K_ENC_IDLE = 3'd3,
    K_FINISH   = 3'd4,
    K_FIN_IDLE = 3'd5
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    logic [CODE_W-1:0]  code;
    logic [LEN_W-1:0]   len;
  } cmd_t;

endpackage

// File: rtl/pcbp_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the input items and the result words.
// Depends on pcbp_pkg for the field widths.
interface pcbp_in_if;
  import pcbp_pkg::*;
  logic              valid;
  logic              ready;
  logic [1:0]        opcode;
  logic [SYM_W-1:0]  symbol;
  logic [CODE_W-1:0] code_bits;
  logic [LEN_W-1:0]  code_length;

  modport source (output valid, opcode, symbol, code_bits, code_length, input ready);
  modport sink   (input valid, opcode, symbol, code_bits, code_length, output ready);
endinterface

interface pcbp_out_if #(parameter int TOTAL_WIDTH = 48);
  import pcbp_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [BYTE_W-1:0]      out_byte;
  logic [VB_W-1:0]        valid_bits;
  logic [TOTAL_WIDTH-1:0] total_bits;
  logic                   status;
  logic                   last;

  modport source (output valid, out_byte, valid_bits, total_bits, status, last, input ready);
  modport sink   (input valid, out_byte, valid_bits, total_bits, status, last, output ready);
endinterface

// File: rtl/pcbp_front.sv
`timescale 1ns / 1ps
// Front end: accepts items, holds the code and length tables, tracks the
// session flag and classifies each item into a command. Depends on pcbp_pkg.
module pcbp_front #(
  parameter int SYMBOL_COUNT = 256,
  parameter int MAX_CODE_LEN = 32
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [1:0]                 in_opcode,
  input  logic [pcbp_pkg::SYM_W-1:0] in_symbol,
  input  logic [pcbp_pkg::CODE_W-1:0] in_code_bits,
  input  logic [pcbp_pkg::LEN_W-1:0] in_code_length,
  output logic                       cmd_valid,
  input  logic                       cmd_ready,
  output pcbp_pkg::cmd_t             cmd
);
  import pcbp_pkg::*;

  localparam int CODE_CAP = (MAX_CODE_LEN > CODE_W) ? CODE_W : MAX_CODE_LEN;
  localparam int IDX_W    = $clog2(SYMBOL_COUNT);

  logic [CODE_W-1:0] code_mem [SYMBOL_COUNT];
  logic [LEN_W-1:0]  len_mem  [SYMBOL_COUNT];

  logic              s1_valid_r;
  kind_t             s1_kind_r;
  logic              s1_sym_ok_r;
  logic              active_r;
  logic [CODE_W-1:0] rd_code_r;
  logic [LEN_W-1:0]  rd_len_r;

  logic              in_acc;
  logic              sym_ok;
  logic [IDX_W-1:0]  idx;
  logic [LEN_W-1:0]  len_cap;
  logic [CODE_W-1:0] code_wr;
  kind_t             kind_nxt;
  logic              active_nxt;

  assign in_ready = !s1_valid_r || cmd_ready;
  assign in_acc   = in_valid && in_ready;
  assign sym_ok   = {1'b0, in_symbol} < (SYM_W + 1)'(SYMBOL_COUNT);
  assign idx      = in_symbol[IDX_W-1:0];

  always_comb begin
    len_cap = (in_code_length > LEN_W'(CODE_CAP)) ? LEN_W'(CODE_CAP) : in_code_length;
    // drop code bits above the stored length; a full-width shift clears the mask
    code_wr = in_code_bits & ~({CODE_W{1'b1}} << len_cap);
  end

  always_comb begin
    kind_nxt   = K_ACK;
    active_nxt = active_r;
    unique case (opcode_t'(in_opcode))
      OP_LOAD:   kind_nxt = K_ACK;
      OP_START: begin
        kind_nxt   = K_START;
        active_nxt = 1'b1;
      end
      OP_ENCODE: kind_nxt = active_r ? K_ENCODE : K_ENC_IDLE;
      OP_FINISH: begin
        kind_nxt   = active_r ? K_FINISH : K_FIN_IDLE;
        active_nxt = 1'b0;
      end
      default:   kind_nxt = K_ACK;
    endcase
  end

  always_ff @(posedge clk) begin
    if (in_acc && opcode_t'(in_opcode) == OP_LOAD && sym_ok) begin
      code_mem[idx] <= code_wr;
      len_mem[idx]  <= len_cap;
    end
    if (in_acc) begin
      rd_code_r <= code_mem[idx];
      rd_len_r  <= len_mem[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      active_r   <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_valid_r  <= 1'b1;
        s1_kind_r   <= kind_nxt;
        s1_sym_ok_r <= sym_ok;
        active_r    <= active_nxt;
      end else if (cmd_ready) begin
        s1_valid_r <= 1'b0;
      end
    end
  end

  assign cmd_valid = s1_valid_r;
  always_comb begin
    cmd.kind = s1_kind_r;
    cmd.code = s1_sym_ok_r ? rd_code_r : '0;
    cmd.len  = s1_sym_ok_r ? rd_len_r : '0;
  end

endmodule

// File: rtl/pcbp_queue.sv
`timescale 1ns / 1ps
// Two-entry command queue between the front end and the byte sequencer.
// Depends on pcbp_pkg for the command word.
module pcbp_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_valid,
  output logic           push_ready,
  input  pcbp_pkg::cmd_t push_cmd,
  output logic           pop_valid,
  input  logic           pop_ready,
  output pcbp_pkg::cmd_t pop_cmd
);
  import pcbp_pkg::*;

  localparam int DEPTH = 2;

  cmd_t       mem_r [DEPTH];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r;
  logic       push;
  logic       pop;

  assign push_ready = count_r != 2'(DEPTH);
  assign pop_valid  = count_r != 2'd0;
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_cmd    = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_cmd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= !wr_ptr_r;
      if (pop)  rd_ptr_r <= !rd_ptr_r;
      unique case ({push, pop})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

// File: rtl/pcbp_back.sv
`timescale 1ns / 1ps
// Byte sequencer: merges codes into the pending bits, emits one word per cycle into
// the output register while it is free and keeps the session bit total. Uses pcbp_pkg.
module pcbp_back #(
  parameter int MAX_CODE_LEN = 32,
  parameter int TOTAL_WIDTH  = 48
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cmd_valid,
  output logic                        cmd_ready,
  input  pcbp_pkg::cmd_t              cmd,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [pcbp_pkg::BYTE_W-1:0] out_byte,
  output logic [pcbp_pkg::VB_W-1:0]   out_valid_bits,
  output logic [TOTAL_WIDTH-1:0]      out_total_bits,
  output logic                        out_status,
  output logic                        out_last
);
  import pcbp_pkg::*;

  localparam int CODE_CAP = (MAX_CODE_LEN > CODE_W) ? CODE_W : MAX_CODE_LEN;
  localparam int ACC_W    = 7 + CODE_CAP;
  localparam int CNT_W    = $clog2(ACC_W + 1);

  typedef enum logic {ST_IDLE, ST_EMIT} state_t;

  state_t                 st_r;
  logic [ACC_W-1:0]       acc_r;
  logic [CNT_W-1:0]       cnt_r;
  logic [TOTAL_WIDTH-1:0] total_r;
  logic                   out_valid_r;
  logic [BYTE_W-1:0]      out_byte_r;
  logic [VB_W-1:0]        valid_bits_r;
  logic [TOTAL_WIDTH-1:0] total_bits_r;
  logic                   status_r;
  logic                   last_r;

  logic                   out_free;
  logic                   pop;
  logic                   below16;
  logic [BYTE_W-1:0]      pend_byte;

  assign out_free  = !out_valid_r || out_ready;
  assign pop       = cmd_valid && st_r == ST_IDLE && (cmd.kind == K_ENCODE || out_free);
  assign cmd_ready = st_r == ST_IDLE && (cmd.kind == K_ENCODE || out_free);
  assign below16   = {1'b0, cnt_r} < (CNT_W + 1)'(16);
  assign pend_byte = acc_r[BYTE_W-1:0] & ~({BYTE_W{1'b1}} << cnt_r[2:0]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      acc_r       <= '0;
      cnt_r       <= '0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      unique case (st_r)
        ST_IDLE: begin
          if (pop) begin
            // an encode merge may run while a word still waits: hold the output register
            if (cmd.kind != K_ENCODE) begin
              out_byte_r   <= '0;
              valid_bits_r <= '0;
              total_bits_r <= '0;
              status_r     <= 1'b0;
              last_r       <= 1'b1;
            end
            unique case (cmd.kind)
              K_ENCODE: begin
                acc_r   <= acc_r | (ACC_W'(cmd.code) << cnt_r[2:0]);
                cnt_r   <= cnt_r + CNT_W'(cmd.len);
                total_r <= total_r + TOTAL_WIDTH'(cmd.len);
                st_r    <= ST_EMIT;
              end
              K_START: begin
                acc_r       <= '0;
                cnt_r       <= '0;
                total_r     <= '0;
                out_valid_r <= 1'b1;
              end
              K_ENC_IDLE: begin
                status_r    <= 1'b1;
                out_valid_r <= 1'b1;
              end
              K_FIN_IDLE: begin
                status_r     <= 1'b1;
                total_bits_r <= total_r;
                out_valid_r  <= 1'b1;
              end
              K_FINISH: begin
                out_byte_r   <= pend_byte;
                valid_bits_r <= VB_W'(cnt_r);
                total_bits_r <= total_r;
                acc_r        <= '0;
                cnt_r        <= '0;
                out_valid_r  <= 1'b1;
              end
              default: out_valid_r <= 1'b1;
            endcase
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            out_valid_r  <= 1'b1;
            total_bits_r <= '0;
            status_r     <= 1'b0;
            if (cnt_r >= CNT_W'(8)) begin
              out_byte_r   <= acc_r[BYTE_W-1:0];
              valid_bits_r <= VB_W'(8);
              last_r       <= below16;
              acc_r        <= acc_r >> 8;
              cnt_r        <= cnt_r - CNT_W'(8);
              if (below16) st_r <= ST_IDLE;
            end else begin
              // no byte completed: plain acknowledgement
              out_byte_r   <= '0;
              valid_bits_r <= '0;
              last_r       <= 1'b1;
              st_r         <= ST_IDLE;
            end
          end
        end
        default: st_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid      = out_valid_r;
  assign out_byte       = out_byte_r;
  assign out_valid_bits = valid_bits_r;
  assign out_total_bits = total_bits_r;
  assign out_status     = status_r;
  assign out_last       = last_r;

  a_idle_partial: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == ST_IDLE |-> cnt_r < CNT_W'(8))
    else $error("pending count not below a byte while idle");

  a_status_no_bits: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && status_r |-> valid_bits_r == '0 && out_byte_r == '0)
    else $error("not-active status word carries code bits");

  a_full_byte_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && valid_bits_r == VB_W'(8) |-> !status_r && total_bits_r == '0)
    else $error("full byte word carries status or total");

endmodule

// File: rtl/prefix_code_bit_packer.sv
`timescale 1ns / 1ps
// Prefix code bit packer: an input item is one of load table entry, start,
// encode byte or finish; encoded bytes leave one per cycle while the output
// is ready, first code bit in bit 0. Load, start and finish each yield one
// result word; encode first merges the code into the pending bits, then
// emits one word per completed byte (or one acknowledgement if none
// completes). The table read in the front end is registered, overlapped
// through a two-entry command queue. The tables are not cleared by reset.
// Depends on pcbp_pkg and the channel interfaces in pcbp_if.
module prefix_code_bit_packer #(
  parameter int SYMBOL_COUNT = 256,
  parameter int MAX_CODE_LEN = 32,
  parameter int TOTAL_WIDTH  = 48
) (
  input  logic       clk,
  input  logic       rst_n,
  pcbp_in_if.sink    in_ch,
  pcbp_out_if.source out_ch
);
  import pcbp_pkg::*;

  logic cmd_valid;
  logic cmd_ready;
  cmd_t cmd;
  logic q_valid;
  logic q_ready;
  cmd_t q_cmd;
  logic [TOTAL_WIDTH-1:0] total_bits;

  pcbp_front #(
    .SYMBOL_COUNT (SYMBOL_COUNT),
    .MAX_CODE_LEN (MAX_CODE_LEN)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_ch.valid),
    .in_ready       (in_ch.ready),
    .in_opcode      (in_ch.opcode),
    .in_symbol      (in_ch.symbol),
    .in_code_bits   (in_ch.code_bits),
    .in_code_length (in_ch.code_length),
    .cmd_valid      (cmd_valid),
    .cmd_ready      (cmd_ready),
    .cmd            (cmd)
  );

  pcbp_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (cmd_valid),
    .push_ready (cmd_ready),
    .push_cmd   (cmd),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_cmd    (q_cmd)
  );

  pcbp_back #(
    .MAX_CODE_LEN (MAX_CODE_LEN),
    .TOTAL_WIDTH  (TOTAL_WIDTH)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd_valid      (q_valid),
    .cmd_ready      (q_ready),
    .cmd            (q_cmd),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .out_byte       (out_ch.out_byte),
    .out_valid_bits (out_ch.valid_bits),
    .out_total_bits (total_bits),
    .out_status     (out_ch.status),
    .out_last       (out_ch.last)
  );

  assign out_ch.total_bits = total_bits;

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for prefix_code_bit_packer: drives load, start, encode and finish
// words, predicts packed bytes with its own table and bit queue, and checks every result.
// Depends on pcbp_pkg and the channel interfaces in pcbp_if.
import pcbp_pkg::*;

typedef struct packed {
  logic [BYTE_W-1:0] data;
  logic [VB_W-1:0]   vbits;
  logic [47:0]       total;
  logic              status;
  logic              last;
} packed_word_t;

class pack_scoreboard;
  localparam int CODE_CAP = 32;

  logic [CODE_W-1:0] code_mem [256];
  logic [LEN_W-1:0]  len_mem  [256];
  logic [6:0]        pend_bits;
  logic [2:0]        pend_cnt;
  logic [47:0]       bit_count;
  bit                active;
  packed_word_t      due_q [$];
  int                mismatches;
  int                words_seen;
  int                full_bytes;

  function new();
    pend_bits  = '0;
    pend_cnt   = '0;
    bit_count  = '0;
    active     = 1'b0;
    mismatches = 0;
    words_seen = 0;
    full_bytes = 0;
  endfunction

  function void queue_word(logic [7:0] data, logic [3:0] vbits, logic [47:0] total,
                           logic status, logic last);
    packed_word_t w;
    w.data   = data;
    w.vbits  = vbits;
    w.total  = total;
    w.status = status;
    w.last   = last;
    due_q.push_back(w);
  endfunction

  function int outstanding();
    return due_q.size();
  endfunction

  // Work out every result word caused by one accepted input word.
  function void note_input(opcode_t op, logic [7:0] sym, logic [31:0] code,
                           logic [5:0] len);
    logic [5:0]  eff_len;
    logic [63:0] acc;
    int          count;
    int          nbytes;
    case (op)
      OP_LOAD: begin
        eff_len = (len > CODE_CAP) ? 6'(CODE_CAP) : len;
        if (eff_len < 32) code = code & ((32'd1 << eff_len) - 32'd1);
        code_mem[sym] = code;
        len_mem[sym]  = eff_len;
        queue_word(8'd0, 4'd0, 48'd0, 1'b0, 1'b1);
      end
      OP_START: begin
        pend_bits = '0;
        pend_cnt  = '0;
        bit_count = '0;
        active    = 1'b1;
        queue_word(8'd0, 4'd0, 48'd0, 1'b0, 1'b1);
      end
      OP_ENCODE: begin
        if (!active) begin
          queue_word(8'd0, 4'd0, 48'd0, 1'b1, 1'b1);
        end else begin
          acc       = {57'd0, pend_bits} | ({32'd0, code_mem[sym]} << pend_cnt);
          count     = int'(pend_cnt) + int'(len_mem[sym]);
          bit_count = bit_count + 48'(len_mem[sym]);
          nbytes    = 0;
          while (count >= 8) begin
            // the byte is the item's final one when fewer than 8 bits stay behind
            queue_word(acc[7:0], 4'd8, 48'd0, 1'b0, count < 16);
            acc    = acc >> 8;
            count  = count - 8;
            nbytes = nbytes + 1;
          end
          full_bytes = full_bytes + nbytes;
          pend_cnt   = 3'(count);
          pend_bits  = acc[6:0];
          if (nbytes == 0) queue_word(8'd0, 4'd0, 48'd0, 1'b0, 1'b1);
        end
      end
      default: begin
        if (!active) begin
          queue_word(8'd0, 4'd0, bit_count, 1'b1, 1'b1);
        end else begin
          queue_word({1'b0, pend_bits}, {1'b0, pend_cnt}, bit_count, 1'b0, 1'b1);
          pend_bits = '0;
          pend_cnt  = '0;
          active    = 1'b0;
        end
      end
    endcase
  endfunction

  function void report(string what, packed_word_t want, packed_word_t got);
    mismatches = mismatches + 1;
    if (mismatches <= 10)
      $display("%0t %s: exp byte=%02h vb=%0d total=%0d st=%0b last=%0b | got byte=%02h vb=%0d total=%0d st=%0b last=%0b",
               $time, what, want.data, want.vbits, want.total, want.status, want.last,
               got.data, got.vbits, got.total, got.status, got.last);
  endfunction

  function void check_word(packed_word_t got);
    packed_word_t want;
    words_seen = words_seen + 1;
    if (due_q.size() == 0) begin
      report("unexpected result", '0, got);
      return;
    end
    want = due_q.pop_front();
    if (got.data !== want.data || got.vbits !== want.vbits || got.total !== want.total ||
        got.status !== want.status || got.last !== want.last)
      report("result mismatch", want, got);
  endfunction

  function bit clean();
    if (due_q.size() != 0)
      report($sformatf("%0d results never arrived, first", due_q.size()), due_q[0], '0);
    return mismatches == 0;
  endfunction
endclass

module testbench;
  localparam int STALL_LIMIT = 2000;
  localparam int ITEM_TARGET = 225;

  logic clk;
  logic rst_n;

  pcbp_in_if                        in_ch();
  pcbp_out_if #(.TOTAL_WIDTH(48))   out_ch();

  prefix_code_bit_packer #(
    .SYMBOL_COUNT(256),
    .MAX_CODE_LEN(32),
    .TOTAL_WIDTH (48)
  ) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  pack_scoreboard sb;
  int   in_idle_pct  = 23;
  int   out_idle_pct = 23;
  int   items_sent   = 0;
  int   op_count [4] = '{0, 0, 0, 0};
  int   stall_cycles = 0;
  bit   sym_loaded [256];
  logic [7:0] loaded_syms [$];

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Result side: stall at random, except during the quiet stretch.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      out_ch.ready <= ($urandom_range(0, 99) >= out_idle_pct);
    end
  end

  // Sample both channels at the edge; feed the scoreboard and the watchdog.
  always @(posedge clk) begin
    packed_word_t got;
    bit           moved;
    moved = 1'b0;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        sb.note_input(opcode_t'(in_ch.opcode), in_ch.symbol, in_ch.code_bits,
                      in_ch.code_length);
        moved = 1'b1;
      end
      if (out_ch.valid && out_ch.ready) begin
        got.data   = out_ch.out_byte;
        got.vbits  = out_ch.valid_bits;
        got.total  = out_ch.total_bits;
        got.status = out_ch.status;
        got.last   = out_ch.last;
        sb.check_word(got);
        moved = 1'b1;
      end
      if (moved) begin
        stall_cycles = 0;
      end else begin
        stall_cycles = stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
          $display("watchdog: no word moved for %0d cycles", STALL_LIMIT);
          $display("prefix_code_bit_packer regression: fail");
          $finish;
        end
      end
    end
  end

  // Present one word and hold it until accepted; valid stays high into the next word.
  task automatic send_item(input opcode_t op, input logic [7:0] sym,
                           input logic [31:0] code, input logic [5:0] len);
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.opcode      <= op;
    in_ch.symbol      <= sym;
    in_ch.code_bits   <= code;
    in_ch.code_length <= len;
    do @(posedge clk); while (!in_ch.ready);
    items_sent   = items_sent + 1;
    op_count[op] = op_count[op] + 1;
  endtask

  task automatic load_entry(input logic [7:0] sym, input logic [31:0] code,
                            input logic [5:0] len);
    send_item(OP_LOAD, sym, code, len);
    if (!sym_loaded[sym]) begin
      sym_loaded[sym] = 1'b1;
      loaded_syms.push_back(sym);
    end
  endtask

  // Hold the sender until every predicted result has come back.
  task automatic drain();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (sb.outstanding() != 0);
  endtask

  // Start, encode and finish words name only symbols with a loaded entry.
  function automatic logic [7:0] pick_loaded();
    return loaded_syms[$urandom_range(0, loaded_syms.size() - 1)];
  endfunction

  function automatic logic [5:0] pick_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 6'($urandom_range(1, 12));
    if (r < 85) return 6'($urandom_range(13, 32));
    if (r < 95) return 6'($urandom_range(33, 63));
    return 6'd0;
  endfunction

  task automatic send_op(input opcode_t op);
    send_item(op, pick_loaded(), $urandom, 6'($urandom_range(0, 63)));
  endtask

  initial begin
    int  pick;
    bit  paused;
    rst_n              = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.opcode       = OP_LOAD;
    in_ch.symbol       = '0;
    in_ch.code_bits    = '0;
    in_ch.code_length  = '0;
    paused             = 1'b0;
    sb = new();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: table extremes, saturation, masking, inactive status, restart, empty finish.
    load_entry(8'h00, 32'hFFFF_FFFF, 6'd0);
    load_entry(8'hFF, 32'hFFFF_FFFF, 6'd32);
    load_entry(8'h55, 32'hA5A5_A5A5, 6'd63);
    load_entry(8'hAA, 32'hFFFF_FFFF, 6'd1);
    load_entry(8'h0F, 32'h0000_005A, 6'd7);
    load_entry(8'hF0, 32'h0000_00C3, 6'd8);
    send_item(OP_FINISH, 8'h00, 32'h0, 6'd0);
    send_item(OP_ENCODE, 8'hFF, 32'h0, 6'd0);
    send_item(OP_START,  8'h00, 32'h0, 6'd0);
    send_item(OP_ENCODE, 8'hAA, 32'h0, 6'd0);
    send_item(OP_ENCODE, 8'h0F, 32'h0, 6'd0);
    send_item(OP_ENCODE, 8'h00, 32'h0, 6'd0);
    send_item(OP_ENCODE, 8'h0F, 32'h0, 6'd0);
    send_item(OP_ENCODE, 8'hFF, 32'h0, 6'd0);
    send_item(OP_ENCODE, 8'h55, 32'h0, 6'd0);
    send_item(OP_ENCODE, 8'hF0, 32'h0, 6'd0);
    send_item(OP_START,  8'h00, 32'h0, 6'd0);
    send_item(OP_ENCODE, 8'h0F, 32'h0, 6'd0);
    load_entry(8'h33, 32'hDEAD_BEEF, 6'd13);
    send_item(OP_ENCODE, 8'h33, 32'h0, 6'd0);
    send_item(OP_FINISH, 8'h00, 32'h0, 6'd0);
    send_item(OP_FINISH, 8'h00, 32'h0, 6'd0);
    send_item(OP_ENCODE, 8'h0F, 32'h0, 6'd0);
    send_item(OP_START,  8'h00, 32'h0, 6'd0);
    send_item(OP_FINISH, 8'h00, 32'h0, 6'd0);
    drain();

    // Random: mostly whole sessions, plus load bursts and stray encode/finish words.
    while (items_sent < ITEM_TARGET) begin
      if (items_sent >= 110 && items_sent < 170) begin
        in_idle_pct  = 0;
        out_idle_pct = 0;
      end else begin
        in_idle_pct  = 23;
        out_idle_pct = 23;
      end
      if (!paused && items_sent >= 180) begin
        drain();
        paused = 1'b1;
      end
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        send_op(OP_START);
        repeat ($urandom_range(1, 10)) begin
          if ($urandom_range(0, 9) == 0)
            load_entry(8'($urandom_range(0, 255)), $urandom, pick_len());
          else
            send_op(OP_ENCODE);
        end
        // leave some sessions open so the next start restarts them
        if ($urandom_range(0, 9) != 0) send_op(OP_FINISH);
      end else if (pick < 85) begin
        repeat ($urandom_range(1, 3))
          load_entry(8'($urandom_range(0, 255)), $urandom, pick_len());
      end else if (pick < 93) begin
        send_op(OP_ENCODE);
      end else begin
        send_op(OP_FINISH);
      end
    end

    drain();
    repeat (16) @(posedge clk);

    $display("covered %0d words: %0d loads, %0d starts, %0d encodes, %0d finishes",
             items_sent, op_count[OP_LOAD], op_count[OP_START], op_count[OP_ENCODE],
             op_count[OP_FINISH]);
    $display("checked %0d result words, %0d of them full bytes, %0d table entries in use",
             sb.words_seen, sb.full_bytes, loaded_syms.size());
    if (sb.clean())
      $display("prefix_code_bit_packer regression: pass");
    else
      $display("prefix_code_bit_packer regression: fail");
    $finish;
  end
endmodule

// File: files.f
rtl/pcbp_pkg.sv
rtl/pcbp_if.sv
rtl/pcbp_front.sv
rtl/pcbp_queue.sv
rtl/pcbp_back.sv
rtl/prefix_code_bit_packer.sv
tb/testbench.sv
